// File: rtl/core/fbrw_pkg.sv
// Shared types and constants of the framebuffer rectangle writer.
// Used by fbrw_engine and framebuffer_rectangle_writer; depends on nothing.
`timescale 1ns / 1ps

package fbrw_pkg;

    // Field widths
    localparam int DIM_BITS       = 12;
    localparam int COL_BITS       = DIM_BITS + 2;
    localparam int BPP_BITS       = 3;
    localparam int PITCH_BITS     = 14;
    localparam int ADDR_BITS      = 32;
    localparam int LEN_BITS       = 32;
    localparam int BYTE_BITS      = 8;
    localparam int STATUS_BITS    = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    // Largest pixel size in bytes; larger settings are clamped to it
    localparam logic [BPP_BITS-1:0] BPP_LIMIT = BPP_BITS'(4);

    // Register values after reset
    localparam logic [ADDR_BITS-1:0]  RESET_FRAME_BASE = '0;
    localparam logic [DIM_BITS-1:0]   RESET_FB_WIDTH   = DIM_BITS'(800);
    localparam logic [DIM_BITS-1:0]   RESET_FB_HEIGHT  = DIM_BITS'(480);
    localparam logic [BPP_BITS-1:0]   RESET_BPP        = BPP_BITS'(2);
    localparam logic [PITCH_BITS-1:0] RESET_ROW_PITCH  = PITCH_BITS'(1600);

    typedef enum logic
    {
        OP_SET_RECT  = 1'b0,
        OP_DATA_BYTE = 1'b1
    } op_t;

    typedef enum logic [STATUS_BITS-1:0]
    {
        STATUS_OK     = 2'd0,
        STATUS_REJECT = 2'd1,
        STATUS_DROP   = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_BITS-1:0]
    {
        CFG_FRAME_BASE = 3'd0,
        CFG_FB_WIDTH   = 3'd1,
        CFG_FB_HEIGHT  = 3'd2,
        CFG_BPP        = 3'd3,
        CFG_ROW_PITCH  = 3'd4
    } cfg_index_t;

    typedef struct packed
    {
        logic [ADDR_BITS-1:0]  frame_base;
        logic [DIM_BITS-1:0]   fb_width;
        logic [DIM_BITS-1:0]   fb_height;
        logic [BPP_BITS-1:0]   bytes_per_pixel;
        logic [PITCH_BITS-1:0] row_pitch;
    } cfg_t;

    typedef struct packed
    {
        op_t                   operation;
        logic [DIM_BITS-1:0]   rect_x;
        logic [DIM_BITS-1:0]   rect_y;
        logic [DIM_BITS-1:0]   rect_width;
        logic [DIM_BITS-1:0]   rect_height;
        logic [LEN_BITS-1:0]   transfer_length;
        logic [BYTE_BITS-1:0]  data_byte;
        logic                  last_byte;
    } item_t;

    typedef struct packed
    {
        status_t               status;
        logic                  write_enable;
        logic [ADDR_BITS-1:0]  write_address;
        logic [BYTE_BITS-1:0]  write_data;
        logic [LEN_BITS-1:0]   length_echo;
        logic                  transfer_error;
    } result_t;

endpackage

// File: rtl/core/fbrw_engine.sv
// Rectangle state and address generation of the framebuffer rectangle writer.
// Depends on fbrw_pkg; driven by framebuffer_rectangle_writer.
`timescale 1ns / 1ps

module fbrw_engine
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  fbrw_pkg::item_t  item,
    input  fbrw_pkg::cfg_t   cfg,
    output fbrw_pkg::result_t result
);
    import fbrw_pkg::*;

    localparam int LINE_BITS = DIM_BITS + 1;
    localparam int LOFF_BITS = LINE_BITS + PITCH_BITS;
    localparam int XOFF_BITS = DIM_BITS + BPP_BITS;

    // Stored rectangle and walk position
    logic [DIM_BITS-1:0] rect_x_reg, rect_x_next;
    logic [DIM_BITS-1:0] rect_y_reg, rect_y_next;
    logic [DIM_BITS-1:0] rect_w_reg, rect_w_next;
    logic [DIM_BITS-1:0] rect_h_reg, rect_h_next;
    logic [DIM_BITS-1:0] row_reg, row_next;
    logic [COL_BITS-1:0] col_reg, col_next;
    logic                overflow_reg, overflow_next;

    logic [LINE_BITS-1:0] x_end;
    logic [LINE_BITS-1:0] y_end;
    logic                 rect_bad;
    logic [BPP_BITS-1:0]  bpp_eff;
    logic [XOFF_BITS-1:0] row_len_full;
    logic [COL_BITS-1:0]  row_len;
    logic [LINE_BITS-1:0] line;
    logic [LOFF_BITS-1:0] line_off;
    logic [XOFF_BITS-1:0] x_off;
    logic [ADDR_BITS-1:0] address;
    logic [COL_BITS-1:0]  col_inc;
    logic                 in_rect;
    logic                 overflow_now;

    // Check the requested rectangle against the framebuffer
    assign x_end = LINE_BITS'(item.rect_x) + LINE_BITS'(item.rect_width);
    assign y_end = LINE_BITS'(item.rect_y) + LINE_BITS'(item.rect_height);
    assign rect_bad = (item.rect_x >= cfg.fb_width) || (item.rect_width > cfg.fb_width)
                   || (item.rect_y >= cfg.fb_height) || (item.rect_height > cfg.fb_height)
                   || (x_end > LINE_BITS'(cfg.fb_width))
                   || (y_end > LINE_BITS'(cfg.fb_height));

    // Clamp pixel size and form the row length in bytes
    assign bpp_eff      = (cfg.bytes_per_pixel > BPP_LIMIT) ? BPP_LIMIT : cfg.bytes_per_pixel;
    assign row_len_full = XOFF_BITS'(rect_w_reg) * XOFF_BITS'(bpp_eff);
    assign row_len      = row_len_full[COL_BITS-1:0];

    // Byte address of the current position
    assign line     = LINE_BITS'(rect_y_reg) + LINE_BITS'(row_reg);
    assign line_off = LOFF_BITS'(line) * LOFF_BITS'(cfg.row_pitch);
    assign x_off    = XOFF_BITS'(rect_x_reg) * XOFF_BITS'(bpp_eff);
    assign address  = cfg.frame_base + ADDR_BITS'(line_off) + ADDR_BITS'(x_off)
                    + ADDR_BITS'(col_reg);

    assign col_inc = col_reg + COL_BITS'(1);
    assign in_rect = (row_len != '0) && (row_reg < rect_h_reg);

    // Next state and result of one request
    always_comb
    begin
        rect_x_next   = rect_x_reg;
        rect_y_next   = rect_y_reg;
        rect_w_next   = rect_w_reg;
        rect_h_next   = rect_h_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        overflow_next = overflow_reg;
        overflow_now  = overflow_reg;
        result        = '0;
        result.status = STATUS_OK;

        unique case (item.operation)
            OP_SET_RECT:
            begin
                if (rect_bad)
                begin
                    result.status = STATUS_REJECT;
                end
                else
                begin
                    rect_x_next        = item.rect_x;
                    rect_y_next        = item.rect_y;
                    rect_w_next        = item.rect_width;
                    rect_h_next        = item.rect_height;
                    row_next           = '0;
                    col_next           = '0;
                    overflow_next      = 1'b0;
                    result.length_echo = item.transfer_length;
                end
            end
            OP_DATA_BYTE:
            begin
                if (in_rect)
                begin
                    result.write_enable  = 1'b1;
                    result.write_address = address;
                    result.write_data    = item.data_byte;
                    if (col_inc >= row_len)
                    begin
                        col_next = '0;
                        row_next = row_reg + DIM_BITS'(1);
                    end
                    else
                    begin
                        col_next = col_inc;
                    end
                end
                else
                begin
                    result.status = STATUS_DROP;
                    overflow_now  = 1'b1;
                end
                overflow_next = overflow_now;
                // Report and rewind at the end of a transfer
                if (item.last_byte)
                begin
                    result.transfer_error = overflow_now;
                    row_next              = '0;
                    col_next              = '0;
                    overflow_next         = 1'b0;
                end
            end
            default:
            begin
                result.status = STATUS_OK;
            end
        endcase
    end

    // Advance state once per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_x_reg   <= '0;
            rect_y_reg   <= '0;
            rect_w_reg   <= '0;
            rect_h_reg   <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            overflow_reg <= 1'b0;
        end
        else if (advance)
        begin
            rect_x_reg   <= rect_x_next;
            rect_y_reg   <= rect_y_next;
            rect_w_reg   <= rect_w_next;
            rect_h_reg   <= rect_h_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            overflow_reg <= overflow_next;
        end
    end

endmodule

// File: rtl/core/framebuffer_rectangle_writer.sv
// Top level of the framebuffer rectangle writer: configuration registers,
// request and result registers around fbrw_engine. Depends on fbrw_pkg.
//
// Usage:
//   Requests arrive on in_valid/in_ready. operation selects a set-rectangle
//   request (checked against fb_width/fb_height, stored and its transfer_length
//   echoed if it fits) or a data byte (written at the next position of
//   the stored rectangle, or dropped with status 2 beyond it).
//   One result leaves on out_valid/out_ready for every request.
//   Configuration goes through cfg_we/cfg_index/cfg_data, one register per cycle,
//   only while no request is in flight: the user keeps to this, not the block.
// Data path:
//   A taken request sits in the request register and moves into the result
//   register once that has room; out_valid rises when the result arrives.
//   One request per cycle is sustained while out_ready stays high; the address
//   multiplier and position update between the two registers set the clock period.
// Reset and stalls:
//   Reset empties both registers, restores the configuration defaults and
//   clears the stored rectangle (zero width, so data bytes are dropped).
//   When out_ready is low the result is held and in_ready falls once the
//   request register is also full; nothing is lost or repeated.
`timescale 1ns / 1ps

module framebuffer_rectangle_writer
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration
    input  logic                                 cfg_we,
    input  logic [fbrw_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [fbrw_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // Request channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 operation,
    input  logic [fbrw_pkg::DIM_BITS-1:0]        rect_x,
    input  logic [fbrw_pkg::DIM_BITS-1:0]        rect_y,
    input  logic [fbrw_pkg::DIM_BITS-1:0]        rect_width,
    input  logic [fbrw_pkg::DIM_BITS-1:0]        rect_height,
    input  logic [fbrw_pkg::LEN_BITS-1:0]        transfer_length,
    input  logic [fbrw_pkg::BYTE_BITS-1:0]       data_byte,
    input  logic                                 last_byte,
    // Result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [fbrw_pkg::STATUS_BITS-1:0]     status,
    output logic                                 write_enable,
    output logic [fbrw_pkg::ADDR_BITS-1:0]       write_address,
    output logic [fbrw_pkg::BYTE_BITS-1:0]       write_data,
    output logic [fbrw_pkg::LEN_BITS-1:0]        length_echo,
    output logic                                 transfer_error
);
    import fbrw_pkg::*;

    cfg_t    cfg_reg;
    item_t   in_item;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t engine_result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    out_room;
    logic    advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_base      <= RESET_FRAME_BASE;
            cfg_reg.fb_width        <= RESET_FB_WIDTH;
            cfg_reg.fb_height       <= RESET_FB_HEIGHT;
            cfg_reg.bytes_per_pixel <= RESET_BPP;
            cfg_reg.row_pitch       <= RESET_ROW_PITCH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FRAME_BASE: cfg_reg.frame_base      <= cfg_data[ADDR_BITS-1:0];
                CFG_FB_WIDTH:   cfg_reg.fb_width        <= cfg_data[DIM_BITS-1:0];
                CFG_FB_HEIGHT:  cfg_reg.fb_height       <= cfg_data[DIM_BITS-1:0];
                CFG_BPP:        cfg_reg.bytes_per_pixel <= cfg_data[BPP_BITS-1:0];
                CFG_ROW_PITCH:  cfg_reg.row_pitch       <= cfg_data[PITCH_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Gather the request fields
    always_comb
    begin
        in_item.operation       = op_t'(operation);
        in_item.rect_x          = rect_x;
        in_item.rect_y          = rect_y;
        in_item.rect_width      = rect_width;
        in_item.rect_height     = rect_height;
        in_item.transfer_length = transfer_length;
        in_item.data_byte       = data_byte;
        in_item.last_byte       = last_byte;
    end

    // Handshake: the result register frees room, the request register follows
    assign out_room = !out_valid_reg || out_ready;
    assign advance  = item_valid_reg && out_room;
    assign in_ready = !item_valid_reg || out_room;

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    fbrw_engine u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (engine_result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_room)
        begin
            out_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= engine_result;
        end
    end

    // Drive the result ports
    assign out_valid      = out_valid_reg;
    assign status         = result_reg.status;
    assign write_enable   = result_reg.write_enable;
    assign write_address  = result_reg.write_address;
    assign write_data     = result_reg.write_data;
    assign length_echo    = result_reg.length_echo;
    assign transfer_error = result_reg.transfer_error;

endmodule
